@@ rtl/sliding_piece_attack_generator_top_defines.svh @@
// Assertion macros for the sliding piece attack generator.
`ifndef SLIDING_PIECE_ATTACK_GENERATOR_TOP_DEFINES_SVH
`define SLIDING_PIECE_ATTACK_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spa assertion failed");
// Next-cycle implication.
`define SPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spa assertion failed");
`else
`define SPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/spa_pkg.sv @@
// Types, board constants and mask functions for the attack generator.
`timescale 1ns / 1ps
package spa_pkg;

  typedef logic [63:0] bb_t;
  typedef logic [5:0]  sq_t;
  typedef logic [2:0]  cmd_t;

  typedef enum logic [2:0] {
    CMD_KNIGHT = 3'd0,
    CMD_BISHOP = 3'd1,
    CMD_ROOK   = 3'd2,
    CMD_QUEEN  = 3'd3,
    CMD_KING   = 3'd4
  } piece_t;

  localparam int NUM_LINES = 4;
  // Line lanes: bishop uses the diagonals, rook the file and rank.
  localparam int LN_DIAG = 0;
  localparam int LN_ANTI = 1;
  localparam int LN_FILE = 2;
  localparam int LN_RANK = 3;

  localparam bb_t FILE_A_BB = 64'h0101010101010101;
  localparam bb_t FILE_B_BB = 64'h0202020202020202;
  localparam bb_t FILE_G_BB = 64'h4040404040404040;
  localparam bb_t FILE_H_BB = 64'h8080808080808080;
  localparam bb_t RANK_1_BB = 64'h00000000000000ff;
  localparam bb_t DIAG_MAIN = 64'h8040201008040201;
  localparam bb_t ANTI_MAIN = 64'h0102040810204080;

  function automatic bb_t bit_rev64(input bb_t v);
    bb_t r;
    for (int i = 0; i < 64; i++) begin
      r[i] = v[63 - i];
    end
    return r;
  endfunction

  function automatic bb_t diag_mask(input sq_t sq);
    logic [2:0] rk;
    logic [2:0] fl;
    bb_t        m;
    rk = sq[5:3];
    fl = sq[2:0];
    if (rk >= fl) begin
      m = DIAG_MAIN << {3'(rk - fl), 3'b000};
    end else begin
      m = DIAG_MAIN >> {3'(fl - rk), 3'b000};
    end
    return m;
  endfunction

  function automatic bb_t anti_mask(input sq_t sq);
    logic [3:0] s;
    bb_t        m;
    s = {1'b0, sq[5:3]} + {1'b0, sq[2:0]};
    if (s >= 4'd7) begin
      m = ANTI_MAIN << {3'(s - 4'd7), 3'b000};
    end else begin
      m = ANTI_MAIN >> {3'(4'd7 - s), 3'b000};
    end
    return m;
  endfunction

  function automatic bb_t file_mask(input sq_t sq);
    return FILE_A_BB << sq[2:0];
  endfunction

  function automatic bb_t rank_mask(input sq_t sq);
    return RANK_1_BB << {sq[5:3], 3'b000};
  endfunction

  function automatic bb_t knight_att(input bb_t b);
    bb_t not_a;
    bb_t not_h;
    bb_t not_ab;
    bb_t not_gh;
    not_a  = ~FILE_A_BB;
    not_h  = ~FILE_H_BB;
    not_ab = ~(FILE_A_BB | FILE_B_BB);
    not_gh = ~(FILE_G_BB | FILE_H_BB);
    return ((b << 17) & not_a) | ((b << 15) & not_h) |
           ((b << 10) & not_ab) | ((b << 6) & not_gh) |
           ((b >> 17) & not_h) | ((b >> 15) & not_a) |
           ((b >> 10) & not_gh) | ((b >> 6) & not_ab);
  endfunction

  function automatic bb_t king_att(input bb_t b);
    bb_t east;
    bb_t west;
    bb_t row;
    east = (b << 1) & ~FILE_A_BB;
    west = (b >> 1) & ~FILE_H_BB;
    row  = b | east | west;
    return east | west | (row << 8) | (row >> 8);
  endfunction

endpackage

@@ rtl/spa_channels.sv @@
// Valid/ready channel interfaces for the query and attack-set transactions.
`timescale 1ns / 1ps
interface spa_in_if;
  logic          valid;
  logic          ready;
  spa_pkg::cmd_t cmd;
  spa_pkg::sq_t  square;
  spa_pkg::bb_t  occupancy;

  modport source (output valid, output cmd, output square, output occupancy, input ready);
  modport sink   (input valid, input cmd, input square, input occupancy, output ready);
endinterface

interface spa_out_if;
  logic         valid;
  logic         ready;
  spa_pkg::bb_t attacks;

  modport source (output valid, output attacks, input ready);
  modport sink   (input valid, input attacks, output ready);
endinterface

@@ rtl/sliding_piece_attack_generator_top.sv @@
// Sliding piece attack generator: three-stage pipelined attack-set lookup.
//
// Usage:
//   in_chan carries one query per transaction: cmd (0 knight, 1 bishop,
//   2 rook, 3 queen, 4 king, other codes give an empty set), square
//   (rank*8+file) and the 64-bit occupancy. out_chan returns one 64-bit
//   attack set per query, in query order.
//   A query passes the stage 1, 2 and 3 registers to out_chan. Throughput
//   is one query per cycle while out_chan.ready is high: stage 1 builds
//   the line masks, stage 2 runs the eight 64-bit subtractions (forward
//   and reversed per line), stage 3 merges lines and selects by piece kind.
//   Each stage holds a valid bit and loads whenever it is empty or the
//   stage after it moves on, so bubbles are squeezed out.
//   When the receiver stalls, the last stage holds its result and the
//   stages behind it fill; in_chan.ready drops only when all three are full.
//   Synchronous reset empties the pipeline; no other state is kept.
`timescale 1ns / 1ps
`include "sliding_piece_attack_generator_top_defines.svh"
module sliding_piece_attack_generator_top (
  input  logic             clk,
  input  logic             rst_n,
  spa_in_if.sink           in_chan,
  spa_out_if.source        out_chan
);

  localparam int NL = spa_pkg::NUM_LINES;

  // Stage enables
  logic en1;
  logic en2;
  logic en3;

  // Stage 1: masks and masked occupancy
  logic          v1_r;
  spa_pkg::cmd_t cmd1_r;
  spa_pkg::bb_t  orig1_r;
  spa_pkg::bb_t  line1_r [NL];
  spa_pkg::bb_t  occ1_r  [NL];
  spa_pkg::bb_t  orig1_nxt;
  spa_pkg::bb_t  line1_nxt [NL];

  // Stage 2: subtractions and knight/king pattern
  logic          v2_r;
  spa_pkg::cmd_t cmd2_r;
  spa_pkg::bb_t  fwd2_r  [NL];
  spa_pkg::bb_t  bwdr2_r [NL];
  spa_pkg::bb_t  line2_r [NL];
  spa_pkg::bb_t  leap2_r;
  spa_pkg::bb_t  fwd2_nxt  [NL];
  spa_pkg::bb_t  bwdr2_nxt [NL];
  spa_pkg::bb_t  leap2_nxt;

  // Stage 3: merged result
  logic          v3_r;
  spa_pkg::bb_t  att3_r;
  spa_pkg::bb_t  lane3   [NL];
  spa_pkg::bb_t  att3_nxt;

  assign en3 = !v3_r || out_chan.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_chan.ready  = en1;
  assign out_chan.valid = v3_r;
  assign out_chan.attacks = att3_r;

  always_comb begin
    orig1_nxt = spa_pkg::bb_t'(1) << in_chan.square;
    line1_nxt[spa_pkg::LN_DIAG] = spa_pkg::diag_mask(in_chan.square) & ~orig1_nxt;
    line1_nxt[spa_pkg::LN_ANTI] = spa_pkg::anti_mask(in_chan.square) & ~orig1_nxt;
    line1_nxt[spa_pkg::LN_FILE] = spa_pkg::file_mask(in_chan.square) & ~orig1_nxt;
    line1_nxt[spa_pkg::LN_RANK] = spa_pkg::rank_mask(in_chan.square) & ~orig1_nxt;
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      fwd2_nxt[i]  = occ1_r[i] - (orig1_r << 1);
      bwdr2_nxt[i] = spa_pkg::bit_rev64(occ1_r[i]) - (spa_pkg::bit_rev64(orig1_r) << 1);
    end
    if (cmd1_r == spa_pkg::CMD_KNIGHT) begin
      leap2_nxt = spa_pkg::knight_att(orig1_r);
    end else begin
      leap2_nxt = spa_pkg::king_att(orig1_r);
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane3[i] = (fwd2_r[i] ^ spa_pkg::bit_rev64(bwdr2_r[i])) & line2_r[i];
    end
    unique case (cmd2_r) inside
      spa_pkg::CMD_KNIGHT,
      spa_pkg::CMD_KING:   att3_nxt = leap2_r;
      spa_pkg::CMD_BISHOP: att3_nxt = lane3[spa_pkg::LN_DIAG] | lane3[spa_pkg::LN_ANTI];
      spa_pkg::CMD_ROOK:   att3_nxt = lane3[spa_pkg::LN_FILE] | lane3[spa_pkg::LN_RANK];
      spa_pkg::CMD_QUEEN:  att3_nxt = lane3[spa_pkg::LN_DIAG] | lane3[spa_pkg::LN_ANTI] |
                                      lane3[spa_pkg::LN_FILE] | lane3[spa_pkg::LN_RANK];
      default:             att3_nxt = '0;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_chan.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r  <= in_chan.cmd;
      orig1_r <= orig1_nxt;
      for (int i = 0; i < NL; i++) begin
        line1_r[i] <= line1_nxt[i];
        occ1_r[i]  <= in_chan.occupancy & line1_nxt[i];
      end
    end
    if (en2) begin
      cmd2_r  <= cmd1_r;
      leap2_r <= leap2_nxt;
      for (int i = 0; i < NL; i++) begin
        fwd2_r[i]  <= fwd2_nxt[i];
        bwdr2_r[i] <= bwdr2_nxt[i];
        line2_r[i] <= line1_r[i];
      end
    end
    if (en3) begin
      att3_r <= att3_nxt;
    end
  end

  `SPA_ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !in_chan.ready, v1_r && v2_r && v3_r)
  `SPA_ASSERT_NEXT(a_stage1_moves, clk, rst_n, v1_r && en2, v2_r)
  `SPA_ASSERT_NEXT(a_bad_cmd_zero, clk, rst_n, v2_r && en3 && cmd2_r > spa_pkg::CMD_KING, ~|att3_r)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the attack generator: directed and random queries, scoreboarded.
`timescale 1ns / 1ps
import spa_pkg::*;

class attack_scoreboard;
  typedef struct packed {
    cmd_t cmd;
    sq_t  square;
    bb_t  occ;
    bb_t  attacks;
  } query_t;

  query_t pending_q[$];
  int     fail_count;
  int     checked;
  int     kind_seen[8];

  function new();
    fail_count = 0;
    checked    = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
  endfunction

  function bb_t mirror64(bb_t v);
    bb_t r;
    for (int i = 0; i < 64; i++) r[63 - i] = v[i];
    return r;
  endfunction

  // Forward borrow finds the first blocker above the origin, the mirrored one below it.
  function bb_t line_sweep(bb_t origin, bb_t occ, bb_t line);
    bb_t o;
    bb_t fwd;
    bb_t bwd;
    o   = occ & line;
    fwd = o - (origin << 1);
    bwd = mirror64(mirror64(o) - (mirror64(origin) << 1));
    return (fwd ^ bwd) & line;
  endfunction

  function bb_t attack_set(cmd_t cmd, sq_t sq, bb_t occ);
    int  rk;
    int  fl;
    int  dr;
    int  df;
    bb_t origin;
    bb_t file_ln;
    bb_t rank_ln;
    bb_t diag_ln;
    bb_t anti_ln;
    bb_t leap;
    bb_t king_ring;
    bb_t diag_set;
    bb_t orth_set;
    rk        = int'(sq[5:3]);
    fl        = int'(sq[2:0]);
    origin    = 64'd1 << sq;
    file_ln   = '0;
    rank_ln   = '0;
    diag_ln   = '0;
    anti_ln   = '0;
    leap      = '0;
    king_ring = '0;
    // Line masks and leaper patterns from board geometry; origin never included.
    for (int t = 0; t < 64; t++) begin
      dr = t / 8 - rk;
      df = t % 8 - fl;
      if (t != int'(sq)) begin
        file_ln[t]   = (df == 0);
        rank_ln[t]   = (dr == 0);
        diag_ln[t]   = (dr == df);
        anti_ln[t]   = (dr == -df);
        leap[t]      = (dr * dr + df * df == 5);
        king_ring[t] = (dr * dr <= 1) && (df * df <= 1);
      end
    end
    diag_set = line_sweep(origin, occ, diag_ln) | line_sweep(origin, occ, anti_ln);
    orth_set = line_sweep(origin, occ, file_ln) | line_sweep(origin, occ, rank_ln);
    case (cmd)
      CMD_KNIGHT: return leap;
      CMD_BISHOP: return diag_set;
      CMD_ROOK:   return orth_set;
      CMD_QUEEN:  return diag_set | orth_set;
      CMD_KING:   return king_ring;
      default:    return '0;
    endcase
  endfunction

  function void note_query(cmd_t cmd, sq_t sq, bb_t occ);
    query_t q;
    q.cmd     = cmd;
    q.square  = sq;
    q.occ     = occ;
    q.attacks = attack_set(cmd, sq, occ);
    pending_q.insert(pending_q.size(), q);
    kind_seen[cmd]++;
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  task check_result(bb_t got);
    query_t q;
    checked++;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("attack set %h with no query outstanding", got));
      return;
    end
    q = pending_q.pop_front();
    if (got !== q.attacks) begin
      report_mismatch($sformatf("cmd %0d sq %0d occ %h: attacks %h, want %h",
                                q.cmd, q.square, q.occ, got, q.attacks));
    end
  endtask

  function int outstanding();
    return pending_q.size();
  endfunction
endclass

module testbench;
  import spa_pkg::*;

  localparam int   LIMIT_CYCLES     = 400000;
  localparam int   CHOKE_CYCLES     = 300;
  localparam cmd_t FIRST_UNUSED_CMD = 3'd5;
  localparam cmd_t LAST_CMD_CODE    = 3'd7;
  localparam bb_t  ALL_SQUARES      = '1;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   idling = 1'b0;
  bit   choke_req = 1'b0;
  attack_scoreboard board;

  spa_in_if  in_bus ();
  spa_out_if out_bus ();

  sliding_piece_attack_generator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, a few long ones; no gaps while idling is low.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bb_t rand_bb();
    return {$urandom, $urandom};
  endfunction

  function automatic bb_t rand_occ(sq_t sq);
    int style;
    style = $urandom_range(0, 9);
    case (style)
      0:       return '0;
      1:       return ALL_SQUARES;
      2, 3:    return rand_bb() & rand_bb() & rand_bb();
      4:       return rand_bb() | rand_bb();
      5:       return (rand_bb() & rand_bb()) | (64'd1 << sq);
      default: return rand_bb();
    endcase
  endfunction

  task automatic send_query(cmd_t cmd, sq_t sq, bb_t occ);
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= cmd;
    in_bus.square    <= sq;
    in_bus.occupancy <= occ;
    do @(posedge clk); while (!in_bus.ready);
    board.note_query(cmd, sq, occ);
  endtask

  task automatic pause_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic directed_queries();
    sq_t sq;
    for (int k = CMD_KNIGHT; k <= CMD_KING; k++) begin
      send_query(cmd_t'(k), 6'd0, '0);
      send_query(cmd_t'(k), 6'd63, ALL_SQUARES);
    end
    sq = 6'd27;
    send_query(CMD_QUEEN, sq, '0);
    send_query(CMD_QUEEN, sq, ALL_SQUARES);
    send_query(CMD_QUEEN, sq, rand_bb() | (64'd1 << sq));
    sq = 6'd7;
    send_query(CMD_ROOK, sq, 64'd1 << sq);
    send_query(CMD_BISHOP, 6'd56, rand_bb());
    send_query(CMD_KNIGHT, 6'd36, rand_bb());
    send_query(CMD_KING, 6'd7, rand_bb());
    send_query(CMD_KING, 6'd56, rand_bb());
    for (int k = FIRST_UNUSED_CMD; k <= LAST_CMD_CODE; k++) begin
      send_query(cmd_t'(k), sq_t'($urandom_range(0, 63)), rand_bb());
    end
  endtask

  task automatic random_queries(int n);
    cmd_t cmd;
    sq_t  sq;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        cmd = cmd_t'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
      end else begin
        cmd = cmd_t'($urandom_range(CMD_KNIGHT, CMD_KING));
      end
      sq = sq_t'($urandom_range(0, 63));
      send_query(cmd, sq, rand_occ(sq));
      pause_sender();
    end
  endtask

  // Result side: random stalls, plus one long hold when asked.
  initial begin
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) board.check_result(out_bus.attacks);
      if (choke_req) begin
        choke_req = 1'b0;
        stall     = CHOKE_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 99) < 25) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    board            = new();
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = CMD_KNIGHT;
    in_bus.square    = '0;
    in_bus.occupancy = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_queries();
    idling = 1'b1;
    random_queries(500);
    // Hold the result side while queries keep coming so the pipeline backs up.
    idling    = 1'b0;
    choke_req = 1'b1;
    random_queries(60);
    random_queries(280);
    idling = 1'b1;
    random_queries(560);

    in_bus.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("queries: %0d knight, %0d bishop, %0d rook, %0d queen, %0d king, %0d unused code",
             board.kind_seen[CMD_KNIGHT], board.kind_seen[CMD_BISHOP],
             board.kind_seen[CMD_ROOK], board.kind_seen[CMD_QUEEN], board.kind_seen[CMD_KING],
             board.kind_seen[FIRST_UNUSED_CMD] + board.kind_seen[FIRST_UNUSED_CMD + 3'd1] +
             board.kind_seen[LAST_CMD_CODE]);
    $display("%0d attack sets compared, %0d mismatches, one %0d-cycle output hold",
             board.checked, board.fail_count, CHOKE_CYCLES);
    if (board.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ sliding_piece_attack_generator_top.f @@
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_channels.sv
rtl/sliding_piece_attack_generator_top.sv
verif/testbench.sv
